### sv/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg: shared constants and elaboration-time table functions
// Register codes, clamp limits, reset values and the generators for the
// log2 and fractional base-2 exponent tables of the compressor core.
// ----------------------------------------------------------------------------
package slc_pkg;

    // Default sizes
    localparam int SAMPLE_BITS_DEF       = 16;
    localparam int ENVELOPE_BITS_DEF     = 24;
    localparam int LOG_TABLE_ENTRIES_DEF = 64;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_RATIO = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAKEUP    = 3'd4;

    // Reset values
    localparam logic signed [14:0] THRESHOLD_RST = -15'sd5120;
    localparam logic [16:0]        INV_RATIO_RST = 17'd16384;
    localparam logic [15:0]        ATTACK_RST    = 16'd65400;
    localparam logic [15:0]        RELEASE_RST   = 16'd65522;
    localparam logic [15:0]        MAKEUP_RST    = 16'd4096;

    // Clamp limits
    localparam logic signed [14:0] THRESHOLD_MIN = -15'sd15360;
    localparam logic [16:0]        INV_RATIO_MIN = 17'd3277;
    localparam logic [16:0]        INV_RATIO_MAX = 17'd65536;
    localparam logic [15:0]        MAKEUP_MAX    = 16'd40960;

    // Unit conversion factors, Q16
    localparam int DB_PER_OCTAVE_Q16 = 394566;
    localparam int OCTAVE_PER_DB_Q16 = 10885;

    // Truncated integer square root
    function automatic logic [63:0] isqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Shift-subtract long division of 64-bit values
    function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = 64'd0;
        rem = 65'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // log2(1 + k/n) in Q16 by repeated squaring in Q30
    function automatic logic [15:0] log_entry(input int k, input int n);
        logic [63:0] x;
        logic [15:0] res;
        x   = long_div((64'(n) + 64'(k)) << 30, 64'(n));
        res = 16'd0;
        for (int b = 0; b < 16; b++) begin
            x   = (x * x) >> 30;
            res = res << 1;
            if (x >= (64'd2 << 30)) begin
                res[0] = 1'b1;
                x      = x >> 1;
            end
        end
        return res;
    endfunction

    // 2^-(2^-(16-j)) in Q30 for fraction bit j
    function automatic logic [30:0] exp_const(input int j);
        logic [63:0] t;
        t = isqrt(64'd1 << 59);
        for (int i = 15; i > j; i--) begin
            t = isqrt(t << 30);
        end
        return t[30:0];
    endfunction

endpackage

### sv/stereo_linked_compressor_core.sv
// ----------------------------------------------------------------------------
// stereo_linked_compressor_core: stereo-linked feed-forward compressor
// The shared multiplier and the bit-serial exponent loop process one pair
//   at a time; the result then waits until the output register is free.
// Input is taken only when idle, so a new pair is accepted only once the
//   previous result has been loaded into the output register.
// Reset (aresetn low, synchronous): envelope cleared, registers to defaults.
// ----------------------------------------------------------------------------
module stereo_linked_compressor_core #(
    parameter int SAMPLE_BITS       = slc_pkg::SAMPLE_BITS_DEF,
    parameter int ENVELOPE_BITS     = slc_pkg::ENVELOPE_BITS_DEF,
    parameter int LOG_TABLE_ENTRIES = slc_pkg::LOG_TABLE_ENTRIES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input pairs
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: left_sample, right_sample (low bits up), zero padded
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                               s_tlast,   // block_last
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: left_out, right_out (low bits up), zero padded
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    output logic                               m_tlast,   // block_last_out
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [slc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int S   = SAMPLE_BITS;
    localparam int E   = ENVELOPE_BITS;
    localparam int DW  = ((2*S+7)/8)*8;
    localparam int W   = (E + 1 > 32) ? E + 1 : 32;
    localparam int P2  = 2*W;
    localparam int PW  = $clog2(E);
    localparam int KW  = (LOG_TABLE_ENTRIES > 1) ? $clog2(LOG_TABLE_ENTRIES) : 1;
    localparam int LGW = PW + 18;
    localparam int DBW = 18;
    localparam int MW  = 24;

    typedef enum logic [19:0] {
        ST_IDLE  = 20'h00001,
        ST_ENV1  = 20'h00002,
        ST_ENV2  = 20'h00004,
        ST_ENV3  = 20'h00008,
        ST_NORM  = 20'h00010,
        ST_FRAC1 = 20'h00020,
        ST_FRAC2 = 20'h00040,
        ST_DB1   = 20'h00080,
        ST_DB2   = 20'h00100,
        ST_RED1  = 20'h00200,
        ST_RED2  = 20'h00400,
        ST_M1    = 20'h00800,
        ST_M2    = 20'h01000,
        ST_EXPI  = 20'h02000,
        ST_EXPC  = 20'h04000,
        ST_GAIN1 = 20'h08000,
        ST_GAIN2 = 20'h10000,
        ST_OUTL  = 20'h20000,
        ST_OUTR  = 20'h40000,
        ST_OUTW  = 20'h80000
    } state_t;

    // Constant tables
    logic [15:0] log_tab [LOG_TABLE_ENTRIES];
    logic [30:0] exp_tab [16];

    for (genvar gi = 0; gi < LOG_TABLE_ENTRIES; gi++) begin : g_log
        localparam logic [15:0] LOG_VAL = slc_pkg::log_entry(gi, LOG_TABLE_ENTRIES);
        assign log_tab[gi] = LOG_VAL;
    end

    for (genvar gj = 0; gj < 16; gj++) begin : g_exp
        localparam logic [30:0] EXP_VAL = slc_pkg::exp_const(gj);
        assign exp_tab[gj] = EXP_VAL;
    end

    // Registers
    state_t                  state_reg, state_next;
    logic signed [14:0]      thr_reg, thr_next;
    logic [16:0]             inv_reg, inv_next;
    logic [15:0]             att_reg, att_next;
    logic [15:0]             rel_reg, rel_next;
    logic [15:0]             mk_reg, mk_next;
    logic [E-1:0]            env_reg, env_next;
    logic                    mv_reg, mv_next;

    logic signed [S-1:0]     l_reg, l_next;
    logic signed [S-1:0]     r_reg, r_next;
    logic                    last_reg, last_next;
    logic [E-1:0]            det_reg, det_next;
    logic [15:0]             c_reg, c_next;
    logic [E+16:0]           acc_reg, acc_next;
    logic [KW-1:0]           k_reg, k_next;
    logic signed [DBW-1:0]   db_reg, db_next;
    logic                    pos_reg, pos_next;
    logic [15:0]             red_reg, red_next;
    logic [MW-1:0]           m_reg, m_next;
    logic [30:0]             g_reg, g_next;
    logic [3:0]              bit_reg, bit_next;
    logic [16:0]             og_reg, og_next;
    logic [S-1:0]            lres_reg, lres_next;
    logic [S-1:0]            outl_reg, outl_next;
    logic [S-1:0]            outr_reg, outr_next;
    logic                    outlast_reg, outlast_next;

    // Shared units
    logic signed [W-1:0]     mul_a;
    logic signed [W-1:0]     mul_b;
    logic signed [P2-1:0]    prod_reg;
    logic                    norm_start;
    logic                    norm_done;
    logic [E-1:0]            norm_x;
    logic [PW-1:0]           norm_p;

    slc_mul #(.W(W)) u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    slc_norm #(.ENVELOPE_BITS(E)) u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .value   ((env_next == '0) ? E'(1) : env_next),
        .done    (norm_done),
        .x_reg   (norm_x),
        .p_reg   (norm_p)
    );

    // Clamped register views
    logic signed [14:0]      thr_c;
    logic [16:0]             inv_c;
    logic [15:0]             mk_c;
    logic [16:0]             ratio_d;

    always_comb begin
        thr_c = thr_reg;
        if (thr_reg < slc_pkg::THRESHOLD_MIN) begin
            thr_c = slc_pkg::THRESHOLD_MIN;
        end else if (thr_reg > 15'sd0) begin
            thr_c = 15'sd0;
        end
        inv_c = inv_reg;
        if (inv_reg < slc_pkg::INV_RATIO_MIN) begin
            inv_c = slc_pkg::INV_RATIO_MIN;
        end else if (inv_reg > slc_pkg::INV_RATIO_MAX) begin
            inv_c = slc_pkg::INV_RATIO_MAX;
        end
        mk_c    = (mk_reg > slc_pkg::MAKEUP_MAX) ? slc_pkg::MAKEUP_MAX : mk_reg;
        ratio_d = slc_pkg::INV_RATIO_MAX - inv_c;
    end

    // Input detector
    logic signed [S-1:0]     in_l;
    logic signed [S-1:0]     in_r;
    logic [S-1:0]            abs_l;
    logic [S-1:0]            abs_r;
    logic [E-1:0]            in_det;

    assign in_l   = s_tdata[S-1:0];
    assign in_r   = s_tdata[2*S-1:S];
    assign abs_l  = in_l[S-1] ? S'(-in_l) : S'(in_l);
    assign abs_r  = in_r[S-1] ? S'(-in_r) : S'(in_r);
    assign in_det = E'((abs_l > abs_r) ? abs_l : abs_r) << (E - S);

    // Derived datapath values
    logic [15:0]             frac;
    logic signed [PW+1:0]    p_exp;
    logic signed [LGW-1:0]   lg;
    logic signed [DBW:0]     over;
    logic [7:0]              m_int;
    logic [30:0]             g_shift;
    logic [E+17:0]           env_sum;

    assign frac    = 16'({norm_x, 16'h0000} >> (E - 1));
    assign p_exp   = $signed({2'b00, norm_p}) - $signed((PW+2)'(E - 1));
    assign lg      = $signed({p_exp, 16'h0000}) + $signed({{(PW+2){1'b0}}, log_tab[k_reg]});
    assign over    = (DBW+1)'(db_reg) - (DBW+1)'(thr_c);
    assign m_int   = m_reg[MW-1:16];
    assign g_shift = (m_int >= 8'd31) ? 31'd0 : (g_reg >> m_int);
    assign env_sum = (E+18)'(acc_reg) + (E+18)'(prod_reg) + (E+18)'(32768);

    // Round, shift by 12 and saturate one output sample
    function automatic logic [S-1:0] sat_sample(input logic signed [P2-1:0] pr);
        logic signed [P2-1:0] y;
        logic signed [P2-1:0] lim_hi;
        logic signed [P2-1:0] lim_lo;
        y      = (pr + P2'(2048)) >>> 12;
        lim_hi = P2'((64'd1 << (S - 1)) - 64'd1);
        lim_lo = -(P2'(64'd1 << (S - 1)));
        if (y > lim_hi) begin
            y = lim_hi;
        end else if (y < lim_lo) begin
            y = lim_lo;
        end
        return S'(y);
    endfunction

    // Steer multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ENV1: begin
                mul_a = W'(c_reg);
                mul_b = W'(env_reg);
            end
            ST_ENV2: begin
                mul_a = W'(17'h10000 - {1'b0, c_reg});
                mul_b = W'(det_reg);
            end
            ST_FRAC1: begin
                mul_a = W'(frac);
                mul_b = W'(LOG_TABLE_ENTRIES);
            end
            ST_DB1: begin
                mul_a = W'(lg);
                mul_b = W'(slc_pkg::DB_PER_OCTAVE_Q16);
            end
            ST_RED1: begin
                mul_a = W'(over);
                mul_b = W'(ratio_d);
            end
            ST_M1: begin
                mul_a = W'(red_reg);
                mul_b = W'(slc_pkg::OCTAVE_PER_DB_Q16);
            end
            ST_EXPI: begin
                mul_a = W'(g_reg);
                mul_b = W'(exp_tab[bit_reg]);
            end
            ST_GAIN1: begin
                mul_a = W'(g_shift);
                mul_b = W'(mk_c);
            end
            ST_OUTL: begin
                mul_a = W'(l_reg);
                mul_b = W'(og_reg);
            end
            ST_OUTR, ST_OUTW: begin
                mul_a = W'(r_reg);
                mul_b = W'(og_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = DW'({outr_reg, outl_reg});
    assign m_tlast   = outlast_reg;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        thr_next     = thr_reg;
        inv_next     = inv_reg;
        att_next     = att_reg;
        rel_next     = rel_reg;
        mk_next      = mk_reg;
        env_next     = env_reg;
        mv_next      = mv_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        last_next    = last_reg;
        det_next     = det_reg;
        c_next       = c_reg;
        acc_next     = acc_reg;
        k_next       = k_reg;
        db_next      = db_reg;
        pos_next     = pos_reg;
        red_next     = red_reg;
        m_next       = m_reg;
        g_next       = g_reg;
        bit_next     = bit_reg;
        og_next      = og_reg;
        lres_next    = lres_reg;
        outl_next    = outl_reg;
        outr_next    = outr_reg;
        outlast_next = outlast_reg;
        norm_start   = 1'b0;

        // register writes
        if (cfg_valid) begin
            case (cfg_index)
                slc_pkg::CFG_THRESHOLD: thr_next = cfg_data[14:0];
                slc_pkg::CFG_INV_RATIO: inv_next = cfg_data[16:0];
                slc_pkg::CFG_ATTACK:    att_next = cfg_data[15:0];
                slc_pkg::CFG_RELEASE:   rel_next = cfg_data[15:0];
                slc_pkg::CFG_MAKEUP:    mk_next  = cfg_data[15:0];
                default: ;
            endcase
        end

        // drop the result once the output transfer completes
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    l_next     = in_l;
                    r_next     = in_r;
                    last_next  = s_tlast;
                    det_next   = in_det;
                    c_next     = (in_det > env_reg) ? att_reg : rel_reg;
                    state_next = ST_ENV1;
                end
            end
            ST_ENV1: state_next = ST_ENV2;
            ST_ENV2: begin
                acc_next   = (E+17)'(prod_reg);
                state_next = ST_ENV3;
            end
            ST_ENV3: begin
                env_next   = E'(env_sum >> 16);
                norm_start = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM: begin
                if (norm_done) begin
                    state_next = ST_FRAC1;
                end
            end
            ST_FRAC1: state_next = ST_FRAC2;
            ST_FRAC2: begin
                k_next     = KW'(prod_reg >> 16);
                state_next = ST_DB1;
            end
            ST_DB1: state_next = ST_DB2;
            ST_DB2: begin
                db_next    = DBW'(prod_reg >>> 24);
                state_next = ST_RED1;
            end
            ST_RED1: begin
                pos_next   = (over > 0);
                state_next = ST_RED2;
            end
            ST_RED2: begin
                red_next   = pos_reg ? 16'((prod_reg + P2'(32768)) >>> 16) : 16'd0;
                state_next = ST_M1;
            end
            ST_M1: state_next = ST_M2;
            ST_M2: begin
                m_next     = MW'((prod_reg + P2'(128)) >>> 8);
                g_next     = 31'h4000_0000;
                bit_next   = 4'd15;
                state_next = ST_EXPI;
            end
            ST_EXPI: begin
                if (m_reg[bit_reg]) begin
                    state_next = ST_EXPC;
                end else if (bit_reg == 4'd0) begin
                    state_next = ST_GAIN1;
                end else begin
                    bit_next = bit_reg - 4'd1;
                end
            end
            ST_EXPC: begin
                g_next = 31'((prod_reg + P2'(64'd1 << 29)) >>> 30);
                if (bit_reg == 4'd0) begin
                    state_next = ST_GAIN1;
                end else begin
                    bit_next   = bit_reg - 4'd1;
                    state_next = ST_EXPI;
                end
            end
            ST_GAIN1: state_next = ST_GAIN2;
            ST_GAIN2: begin
                og_next    = 17'((prod_reg + P2'(64'd1 << 29)) >>> 30);
                state_next = ST_OUTL;
            end
            ST_OUTL: state_next = ST_OUTR;
            ST_OUTR: begin
                lres_next  = sat_sample(prod_reg);
                state_next = ST_OUTW;
            end
            ST_OUTW: begin
                // hold until the output register is free
                if (!mv_reg || m_tready) begin
                    outl_next    = lres_reg;
                    outr_next    = sat_sample(prod_reg);
                    outlast_next = last_reg;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            thr_reg   <= slc_pkg::THRESHOLD_RST;
            inv_reg   <= slc_pkg::INV_RATIO_RST;
            att_reg   <= slc_pkg::ATTACK_RST;
            rel_reg   <= slc_pkg::RELEASE_RST;
            mk_reg    <= slc_pkg::MAKEUP_RST;
            env_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            thr_reg   <= thr_next;
            inv_reg   <= inv_next;
            att_reg   <= att_next;
            rel_reg   <= rel_next;
            mk_reg    <= mk_next;
            env_reg   <= env_next;
            mv_reg    <= mv_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        l_reg       <= l_next;
        r_reg       <= r_next;
        last_reg    <= last_next;
        det_reg     <= det_next;
        c_reg       <= c_next;
        acc_reg     <= acc_next;
        k_reg       <= k_next;
        db_reg      <= db_next;
        pos_reg     <= pos_next;
        red_reg     <= red_next;
        m_reg       <= m_next;
        g_reg       <= g_next;
        bit_reg     <= bit_next;
        og_reg      <= og_next;
        lres_reg    <= lres_next;
        outl_reg    <= outl_next;
        outr_reg    <= outr_next;
        outlast_reg <= outlast_next;
    end

endmodule

### sv/slc_mul.sv
// ----------------------------------------------------------------------------
// slc_mul: shared signed multiplier
// One registered signed product; the sequencer steers operands each cycle
// and picks up the product in the following cycle.
// ----------------------------------------------------------------------------
module slc_mul #(
    parameter int W = 32
) (
    input  logic                  aclk,
    input  logic signed [W-1:0]   mul_a,
    input  logic signed [W-1:0]   mul_b,
    output logic signed [2*W-1:0] prod_reg
);

    // Register the product
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

endmodule

### sv/slc_norm.sv
// ----------------------------------------------------------------------------
// slc_norm: iterative leading-one normalizer
// Binary search over shifts of halving size; leaves the value with its top
// bit set and the position of the original leading one.
// ----------------------------------------------------------------------------
module slc_norm #(
    parameter int ENVELOPE_BITS = slc_pkg::ENVELOPE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [ENVELOPE_BITS-1:0]         value,
    output logic                             done,
    output logic [ENVELOPE_BITS-1:0]         x_reg,
    output logic [$clog2(ENVELOPE_BITS)-1:0] p_reg
);

    localparam int NS = $clog2(ENVELOPE_BITS);

    logic [ENVELOPE_BITS-1:0] x_next;
    logic [NS-1:0]            p_next;
    logic [NS-1:0]            sh_reg;
    logic [NS-1:0]            sh_next;
    logic [ENVELOPE_BITS-1:0] top_mask;

    assign done     = (sh_reg == '0);
    assign top_mask = ~({ENVELOPE_BITS{1'b1}} >> sh_reg);

    // Load on start, then shift out leading zeros one step per cycle
    always_comb begin
        x_next  = x_reg;
        p_next  = p_reg;
        sh_next = sh_reg;
        if (start) begin
            x_next  = value;
            p_next  = NS'(ENVELOPE_BITS - 1);
            sh_next = NS'(1) << (NS - 1);
        end else if (sh_reg != '0) begin
            if ((x_reg & top_mask) == '0) begin
                x_next = x_reg << sh_reg;
                p_next = p_reg - sh_reg;
            end
            sh_next = sh_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sh_reg <= '0;
        end else begin
            sh_reg <= sh_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        p_reg <= p_next;
    end

endmodule
